// ===== sv/pads_pkg.sv =====
// Shared types and codes for the positional insert/delete/search list.
package pads_pkg;

  localparam int KeyW = 32;
  localparam int PosW = 6;
  localparam int CmdW = 2;
  localparam int StatW = 2;
  localparam int CntOutW = 5;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

  localparam logic [StatW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_POS = 2'd1;
  localparam logic [StatW-1:0] ST_FULL    = 2'd2;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic            srch;
    logic [PosW-1:0] pos_m1;
    logic [KeyW-1:0] key;
  } cell_ctl_t;

endpackage

// ===== sv/pads_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors and compares with the key.
module pads_cell import pads_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic            live,
  input  logic [KeyW-1:0] prev_entry,
  input  logic [KeyW-1:0] next_entry,
  output logic [KeyW-1:0] entry,
  output logic            hit
);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (Idx == int'(ctl.pos_m1));
  assign past_pos = (Idx > int'(ctl.pos_m1));

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (past_pos) begin
        entry <= prev_entry;
      end else if (at_pos) begin
        entry <= ctl.key;
      end
    end else if (ctl.del) begin
      if (past_pos || at_pos) begin
        entry <= next_entry;
      end
    end
  end

  // Only slots below the count take part in a search.
  always_ff @(posedge clk) begin
    hit <= ctl.srch && live && (entry == ctl.key);
  end

endmodule

// ===== sv/positional_array_insert_delete_search.sv =====
// Top level: controller and row of list cells.
// The result strobe (done) comes in the cycle after the command is taken.
// Throughput: one command per cycle; every cell shifts or compares in parallel
// and the search hits are OR-reduced in the result cycle.
// busy stays low. Reset empties the list (count to zero); entries are undefined.
// The receiver cannot stall: each result is on the ports for one cycle only.
module positional_array_insert_delete_search import pads_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CmdW-1:0]    command,
  input  logic [PosW-1:0]    position,
  input  logic [KeyW-1:0]    key,
  output logic               done,
  output logic [StatW-1:0]   status,
  output logic               found,
  output logic [CntOutW-1:0] entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > PosW) ? CW : PosW) + 1;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [StatW-1:0] status_next;
  logic            accept;
  logic            ins_ok;
  logic            del_ok;
  logic [PW-1:0]   pos_x;
  logic [PW-1:0]   cnt_x;
  cell_ctl_t       ctl;
  logic [KeyW-1:0] entries [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] live;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_x  = PW'(position);
  assign cnt_x  = PW'(count);

  assign ins_ok = (count != CW'(DEPTH)) && (position != '0) && (pos_x <= cnt_x + PW'(1));
  assign del_ok = (position != '0) && (pos_x <= cnt_x);

  always_comb begin
    ctl.ins    = accept && (command == CMD_INSERT) && ins_ok;
    ctl.del    = accept && (command == CMD_DELETE) && del_ok;
    ctl.srch   = accept && (command == CMD_SEARCH);
    ctl.pos_m1 = position - PosW'(1);
    ctl.key    = key;
  end

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    unique case (command)
      CMD_INSERT: begin
        if (count == CW'(DEPTH)) begin
          status_next = ST_FULL;
        end else if (!ins_ok) begin
          status_next = ST_BAD_POS;
        end else begin
          count_next = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (!del_ok) begin
          status_next = ST_BAD_POS;
        end else begin
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KeyW-1:0] prev_e;
    logic [KeyW-1:0] next_e;

    if (i == 0) begin : g_first
      assign prev_e = key;
    end else begin : g_mid_lo
      assign prev_e = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = entries[i];
    end else begin : g_mid_hi
      assign next_e = entries[i+1];
    end

    assign live[i] = (CW'(i) < count);

    pads_cell #(
      .Idx(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live[i]),
      .prev_entry(prev_e),
      .next_entry(next_e),
      .entry     (entries[i]),
      .hit       (hits[i])
    );
  end

  assign found       = |hits;
  assign entry_count = CntOutW'(count);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the positional insert/delete/search list.
`timescale 1ns / 1ps

module tb import pads_pkg::*; ();

  localparam int LIST_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 19;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  // Phase flavors steer the list between empty and full.
  localparam int PH_FILL = 0;
  localparam int PH_DRAIN = 1;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic               found;
    logic [CntOutW-1:0] entry_count;
  } list_result_t;

  class list_scoreboard;
    logic [KeyW-1:0] held [LIST_DEPTH];
    int unsigned     count;
    list_result_t    pending [$];
    int              errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    // Applies one command to the shadow list and returns the result it gives.
    function list_result_t apply_command(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                         logic [KeyW-1:0] k);
      list_result_t res;
      int p;
      int i;
      p = int'(pos);
      res.status = ST_DONE;
      res.found = 1'b0;
      case (cmd)
        CMD_INSERT: begin
          if (count >= LIST_DEPTH) begin
            res.status = ST_FULL;
          end else if (p == 0 || p > int'(count) + 1) begin
            res.status = ST_BAD_POS;
          end else begin
            for (i = int'(count); i >= p; i--) held[i] = held[i-1];
            held[p-1] = k;
            count++;
          end
        end
        CMD_DELETE: begin
          if (p == 0 || p > int'(count)) begin
            res.status = ST_BAD_POS;
          end else begin
            for (i = p - 1; i + 1 < int'(count); i++) held[i] = held[i+1];
            count--;
          end
        end
        CMD_SEARCH: begin
          for (i = 0; i < int'(count); i++) begin
            if (held[i] == k) res.found = 1'b1;
          end
        end
        default: ;
      endcase
      res.entry_count = count[CntOutW-1:0];
      return res;
    endfunction

    function void note_command(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                               logic [KeyW-1:0] k);
      pending.push_back(apply_command(cmd, pos, k));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [StatW-1:0] st, logic fd, logic [CntOutW-1:0] cnt);
      list_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = pending.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        if (fd !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", fd, want.found));
        if (cnt !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", cnt,
                                    want.entry_count));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CmdW-1:0]    command = CMD_SEARCH;
  logic [PosW-1:0]    position = '0;
  logic [KeyW-1:0]    key = '0;
  logic               busy;
  logic               done;
  logic [StatW-1:0]   status;
  logic               found;
  logic [CntOutW-1:0] entry_count;

  list_scoreboard sb = new();

  positional_array_insert_delete_search #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .position(position),
    .key(key),
    .done(done),
    .status(status),
    .found(found),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are taken before the command transfer of the same edge is noted,
  // so the queue always holds commands in issue order.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, found, entry_count);
      if (start && !busy) sb.note_command(command, position, key);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Holds the command on the ports until the block takes it. busy is looked
  // at on the falling edge, where it is stable for the next rising edge.
  task send_command(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos, logic [KeyW-1:0] k);
    start <= 1'b1;
    command <= cmd;
    position <= pos;
    key <= k;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      command <= CmdW'($urandom);
      position <= PosW'($urandom);
      key <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function logic [CmdW-1:0] pick_command(int flavor);
    int r;
    r = $urandom_range(99);
    case (flavor)
      PH_FILL: begin
        if (r < 60) return CMD_INSERT;
        if (r < 75) return CMD_DELETE;
        if (r < 96) return CMD_SEARCH;
      end
      PH_DRAIN: begin
        if (r < 20) return CMD_INSERT;
        if (r < 75) return CMD_DELETE;
        if (r < 96) return CMD_SEARCH;
      end
      default: begin
        if (r < 38) return CMD_INSERT;
        if (r < 68) return CMD_DELETE;
        if (r < 96) return CMD_SEARCH;
      end
    endcase
    return CMD_UNUSED;
  endfunction

  // A small pool of keys makes duplicates and search hits common.
  function logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 50) return KeyW'($urandom_range(15));
    return $urandom;
  endfunction

  // Mostly legal positions so the list stays busy; the rest sit just past
  // the edges of the legal range or anywhere in the position field.
  function logic [PosW-1:0] pick_position(logic [CmdW-1:0] cmd, int cnt);
    int r;
    int top;
    r = $urandom_range(99);
    top = (cmd == CMD_INSERT) ? cnt + 1 : cnt;
    if (r < 75 && top > 0) return PosW'($urandom_range(top, 1));
    if (r < 88) return ($urandom_range(1) == 0) ? PosW'(0) : PosW'(top + 1);
    return PosW'($urandom_range(63));
  endfunction

  initial begin
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [KeyW-1:0] k;
    int fill;
    int flavor;
    bit gaps_on;
    int cnt;

    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, edge keys, bad positions, full list, unused command.
    send_command(CMD_SEARCH, 6'd0, 32'h0000_0000);
    send_command(CMD_DELETE, 6'd1, 32'h0000_0000);
    send_command(CMD_INSERT, 6'd0, 32'h1234_5678);
    send_command(CMD_INSERT, 6'd2, 32'h1234_5678);
    send_command(CMD_INSERT, 6'd1, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 6'd2, 32'h8000_0000);
    send_command(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 6'd2, 32'h0000_0000);
    send_command(CMD_SEARCH, 6'd63, 32'h8000_0000);
    send_command(CMD_SEARCH, 6'd0, 32'h0000_3039);
    send_command(CMD_UNUSED, 6'd63, 32'hA5A5_5A5A);
    send_command(CMD_DELETE, 6'd63, 32'hFFFF_FFFF);
    send_command(CMD_DELETE, 6'd5, 32'h0000_0000);
    send_command(CMD_DELETE, 6'd2, 32'h0000_0000);
    for (fill = 3; fill < LIST_DEPTH; fill++) begin
      pos = (fill % 2 == 1) ? PosW'(1) : PosW'(fill + 1);
      send_command(CMD_INSERT, pos, 32'h5A5A_0000 + fill);
    end
    send_command(CMD_INSERT, 6'd0, 32'h0000_0042);
    send_command(CMD_INSERT, 6'd1, 32'h0000_0042);
    send_command(CMD_DELETE, 6'd16, 32'h0000_0000);
    send_command(CMD_DELETE, 6'd16, 32'h0000_0000);
    send_command(CMD_SEARCH, 6'd0, 32'h5A5A_0003);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      flavor = phase % 3;
      gaps_on = (phase % 4 != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cnt = int'(sb.count);
        cmd = pick_command(flavor);
        pos = pick_position(cmd, cnt);
        k = pick_key();
        if (cmd == CMD_SEARCH && cnt > 0 && $urandom_range(1) == 1)
          k = sb.held[$urandom_range(cnt - 1)];
        send_command(cmd, pos, k);
        if (gaps_on) idle_gap(pick_gap());
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
